/* rtl/ll1p_pkg.sv */
// Shared types and constants for the LL(1) predictive parser.
`timescale 1ns / 1ps
package ll1p_pkg;
    localparam int NONTERMINALS_DEF   = 16;
    localparam int TERMINALS_DEF      = 16;
    localparam int MAX_RHS_DEF        = 8;
    localparam int STACK_DEPTH_DEF    = 64;
    localparam int MAX_EXPANSIONS_DEF = 64;

    localparam int SYM_W  = 4;
    localparam int ENTRY_W = 5;  // bit 4 terminal flag, bits 3..0 index
    localparam int LEN_W  = 4;

    typedef enum logic [1:0] {
        OP_WR_LEN = 2'd0,
        OP_WR_SYM = 2'd1,
        OP_BEGIN  = 2'd2,
        OP_TOKEN  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_EOF      = 3'd4,
        ST_TRAIL    = 3'd5,
        ST_OVERFLOW = 3'd6,
        ST_LIMIT    = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RUN  = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_POP,
        S_TOP,
        S_LEN,
        S_SYMRD,
        S_PUSH,
        S_RESULT
    } fsm_t;
endpackage

/* rtl/ll1p_table.sv */
// Parse table storage: cell lengths and production symbols, registered read.
`timescale 1ns / 1ps
module ll1p_table #(
    parameter int CELLS   = 256,
    parameter int MAX_RHS = 8
) (
    input  logic                          clk,
    input  logic                          len_we,
    input  logic [$clog2(CELLS)-1:0]      len_waddr,
    input  logic [ll1p_pkg::LEN_W-1:0]    len_wdata,
    input  logic [$clog2(CELLS)-1:0]      len_raddr,
    output logic [ll1p_pkg::LEN_W-1:0]    len_rdata,
    input  logic                          sym_we,
    input  logic [$clog2(CELLS*MAX_RHS)-1:0] sym_waddr,
    input  logic [ll1p_pkg::ENTRY_W-1:0]  sym_wdata,
    input  logic [$clog2(CELLS*MAX_RHS)-1:0] sym_raddr,
    output logic [ll1p_pkg::ENTRY_W-1:0]  sym_rdata
);
    logic [ll1p_pkg::LEN_W-1:0]   len_mem [CELLS];
    logic [ll1p_pkg::ENTRY_W-1:0] sym_mem [CELLS*MAX_RHS];

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata <= len_mem[len_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sym_we)
        begin
            sym_mem[sym_waddr] <= sym_wdata;
        end
        sym_rdata <= sym_mem[sym_raddr];
    end
endmodule

/* rtl/ll1p_stack.sv */
// Symbol stack memory, one write and one registered read per cycle.
`timescale 1ns / 1ps
module ll1p_stack #(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [ll1p_pkg::ENTRY_W-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [ll1p_pkg::ENTRY_W-1:0] rdata
);
    logic [ll1p_pkg::ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/ll1_table_driven_parser.sv */
// Top level of the LL(1) predictive parser: sequencer around table and stack memories.
// Sequence: load and begin transactions go straight to the result. A token transaction
//   pops the stack top; each expansion reads the cell length, then reads and pushes each slot.
// Throughput: one transaction at a time; the next is taken once the result register
//   is free. Loop set by the single read port on the symbol memory.
// Reset: asynchronous, active low. After reset a clearing pass zeroes every cell of the
//   length table; no input is taken during it.
`timescale 1ns / 1ps
module ll1_table_driven_parser #(
    parameter int NONTERMINALS   = ll1p_pkg::NONTERMINALS_DEF,
    parameter int TERMINALS      = ll1p_pkg::TERMINALS_DEF,
    parameter int MAX_RHS        = ll1p_pkg::MAX_RHS_DEF,
    parameter int STACK_DEPTH    = ll1p_pkg::STACK_DEPTH_DEF,
    parameter int MAX_EXPANSIONS = ll1p_pkg::MAX_EXPANSIONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,      // end_terminal
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], row[5:2], column[9:6], position[12:10], symbol[16:13],
    // symbol_is_terminal[17], cell_length[21:18], token[25:22]
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // last_token
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // status[2:0]
);
    localparam int CELLS = NONTERMINALS * TERMINALS;
    localparam int CA_W  = $clog2(CELLS);
    localparam int SA_W  = $clog2(CELLS * MAX_RHS);
    localparam int K_W   = $clog2(MAX_RHS + 1);
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int EX_W  = $clog2(MAX_EXPANSIONS + 1);
    localparam int LEN_W_L = ll1p_pkg::LEN_W;

    // Input field unpacking
    logic [1:0] in_op;
    logic [3:0] in_row, in_col, in_sym, in_len, in_tok;
    logic [2:0] in_pos;
    logic       in_isterm;
    assign in_op     = s_axis_tdata[1:0];
    assign in_row    = s_axis_tdata[5:2];
    assign in_col    = s_axis_tdata[9:6];
    assign in_pos    = s_axis_tdata[12:10];
    assign in_sym    = s_axis_tdata[16:13];
    assign in_isterm = s_axis_tdata[17];
    assign in_len    = s_axis_tdata[21:18];
    assign in_tok    = s_axis_tdata[25:22];

    ll1p_pkg::fsm_t   state_reg, state_next;
    ll1p_pkg::phase_t phase_reg, phase_next;
    logic [3:0]          end_term_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [EX_W-1:0]     exp_reg, exp_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [CA_W-1:0]     cell_reg, cell_next;
    logic [CA_W-1:0]     clr_reg;
    logic [3:0]          tok_reg;
    logic                last_reg;
    logic [2:0]          status_reg, status_next;
    logic                out_valid_reg;
    // Marks a token transaction that ran against the stack (status may end the parse)
    logic                tok_after_run_reg;

    logic                len_we, sym_we, stk_we;
    logic [CA_W-1:0]     len_waddr;
    logic [LEN_W_L-1:0]  len_wdata;
    logic [ll1p_pkg::LEN_W-1:0]   len_rdata;
    logic [SA_W-1:0]     sym_waddr, sym_raddr;
    logic [ll1p_pkg::ENTRY_W-1:0] sym_wdata, sym_rdata, stk_wdata, stk_rdata;
    logic [SP_W-1:0]     stk_waddr, stk_raddr;

    logic accept_in;
    assign s_axis_tready = (state_reg == ll1p_pkg::S_IDLE) && !out_valid_reg;
    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, status_reg};

    // Table cell index from load fields, with range checks
    logic load_in_range, pos_in_range;
    logic [CA_W-1:0] load_cell;
    assign load_in_range = (32'(in_row) < NONTERMINALS) && (32'(in_col) < TERMINALS);
    assign pos_in_range  = 32'(in_pos) < MAX_RHS;
    assign load_cell = CA_W'(32'(in_row) * TERMINALS + 32'(in_col));

    logic [LEN_W_L-1:0] len_sat;
    assign len_sat = (32'(in_len) > MAX_RHS) ? LEN_W_L'(MAX_RHS) : in_len;

    // Memory write ports
    always_comb
    begin
        len_we    = 1'b0;
        len_waddr = load_cell;
        len_wdata = len_sat;
        if (state_reg == ll1p_pkg::S_CLEAR)
        begin
            len_we    = 1'b1;
            len_waddr = clr_reg;
            len_wdata = '0;
        end
        else if (accept_in && in_op == ll1p_pkg::OP_WR_LEN && load_in_range)
        begin
            len_we = 1'b1;
        end
    end

    assign sym_we    = accept_in && in_op == ll1p_pkg::OP_WR_SYM && load_in_range && pos_in_range;
    assign sym_waddr = SA_W'(32'(load_cell) * MAX_RHS + 32'(in_pos));
    assign sym_wdata = {in_isterm, in_sym};
    assign sym_raddr = SA_W'(32'(cell_reg) * MAX_RHS + 32'(k_reg) - 1);

    // Stack write: begin writes the bottom on acceptance and the start symbol via begin_second_reg.
    logic begin_second_reg;
    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = {1'b1, end_term_reg};
        if (accept_in && in_op == ll1p_pkg::OP_BEGIN)
        begin
            stk_we = 1'b1;
        end
        else if (begin_second_reg)
        begin
            stk_we    = 1'b1;
            stk_waddr = SP_W'(1);
            stk_wdata = '0;
        end
        else if (state_reg == ll1p_pkg::S_PUSH && sym_rdata != 5'h10
                 && 32'(cnt_reg) < STACK_DEPTH)
        begin
            stk_we    = 1'b1;
            stk_waddr = SP_W'(cnt_reg);
            stk_wdata = sym_rdata;
        end
    end
    assign stk_raddr = SP_W'(cnt_reg - CNT_W'(1));

    // Length read is issued with the cell being looked up, so it lands in S_LEN
    ll1p_table #(.CELLS(CELLS), .MAX_RHS(MAX_RHS)) u_table (
        .clk(clk), .len_we(len_we), .len_waddr(len_waddr), .len_wdata(len_wdata),
        .len_raddr(cell_next), .len_rdata(len_rdata),
        .sym_we(sym_we), .sym_waddr(sym_waddr), .sym_wdata(sym_wdata),
        .sym_raddr(sym_raddr), .sym_rdata(sym_rdata)
    );

    ll1p_stack #(.DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    // Lookup cell for the popped nonterminal
    logic nt_in_range;
    assign nt_in_range = (32'(stk_rdata[3:0]) < NONTERMINALS) && (32'(tok_reg) < TERMINALS);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ll1p_pkg::S_CLEAR:
                if (32'(clr_reg) == CELLS - 1) state_next = ll1p_pkg::S_IDLE;
            ll1p_pkg::S_IDLE:
                if (accept_in)
                begin
                    if (in_op == ll1p_pkg::OP_TOKEN && phase_reg == ll1p_pkg::PH_RUN)
                        state_next = ll1p_pkg::S_POP;
                    else
                        state_next = ll1p_pkg::S_RESULT;
                end
            ll1p_pkg::S_POP:
                state_next = (cnt_reg == '0) ? ll1p_pkg::S_RESULT : ll1p_pkg::S_TOP;
            ll1p_pkg::S_TOP:
                if (stk_rdata[4] || 32'(exp_reg) >= MAX_EXPANSIONS || !nt_in_range)
                    state_next = ll1p_pkg::S_RESULT;
                else
                    state_next = ll1p_pkg::S_LEN;
            ll1p_pkg::S_LEN:
                state_next = (len_rdata == '0) ? ll1p_pkg::S_RESULT : ll1p_pkg::S_SYMRD;
            ll1p_pkg::S_SYMRD:
                state_next = ll1p_pkg::S_PUSH;
            ll1p_pkg::S_PUSH:
                if (sym_rdata != 5'h10 && 32'(cnt_reg) >= STACK_DEPTH)
                    state_next = ll1p_pkg::S_RESULT;
                else if (k_reg == K_W'(1))
                    state_next = ll1p_pkg::S_POP;
                else
                    state_next = ll1p_pkg::S_SYMRD;
            ll1p_pkg::S_RESULT:
                state_next = ll1p_pkg::S_IDLE;
            default:
                state_next = ll1p_pkg::S_IDLE;
        endcase
    end

    // Datapath updates
    always_comb
    begin
        cnt_next    = cnt_reg;
        exp_next    = exp_reg;
        k_next      = k_reg;
        cell_next   = cell_reg;
        status_next = status_reg;
        phase_next  = phase_reg;
        case (state_reg)
            ll1p_pkg::S_IDLE:
                if (accept_in)
                begin
                    status_next = ll1p_pkg::ST_OK;
                    exp_next    = '0;
                    if (in_op == ll1p_pkg::OP_BEGIN)
                    begin
                        cnt_next   = CNT_W'(2);
                        phase_next = ll1p_pkg::PH_RUN;
                    end
                    else if (in_op == ll1p_pkg::OP_TOKEN && phase_reg != ll1p_pkg::PH_RUN)
                        status_next = ll1p_pkg::ST_TRAIL;
                end
            ll1p_pkg::S_POP:
                if (cnt_reg == '0)
                    status_next = ll1p_pkg::ST_TRAIL;
                else
                    cnt_next = cnt_reg - CNT_W'(1);
            ll1p_pkg::S_TOP:
            begin
                cell_next = CA_W'(32'(stk_rdata[3:0]) * TERMINALS + 32'(tok_reg));
                if (stk_rdata[4])
                begin
                    if (stk_rdata[3:0] != tok_reg)
                        status_next = ll1p_pkg::ST_MISMATCH;
                    else if (cnt_reg == '0)
                        status_next = last_reg ? ll1p_pkg::ST_ACCEPT : ll1p_pkg::ST_TRAIL;
                    else
                        status_next = last_reg ? ll1p_pkg::ST_EOF : ll1p_pkg::ST_OK;
                end
                else if (32'(exp_reg) >= MAX_EXPANSIONS)
                    status_next = ll1p_pkg::ST_LIMIT;
                else if (!nt_in_range)
                    status_next = ll1p_pkg::ST_EMPTY;
                else
                    exp_next = exp_reg + EX_W'(1);
            end
            ll1p_pkg::S_LEN:
                if (len_rdata == '0)
                    status_next = ll1p_pkg::ST_EMPTY;
                else
                    k_next = K_W'(len_rdata);
            ll1p_pkg::S_PUSH:
                if (sym_rdata != 5'h10)
                begin
                    if (32'(cnt_reg) >= STACK_DEPTH)
                        status_next = ll1p_pkg::ST_OVERFLOW;
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                        k_next   = k_reg - K_W'(1);
                    end
                end
                else
                    k_next = k_reg - K_W'(1);
            ll1p_pkg::S_RESULT:
                if (status_reg != ll1p_pkg::ST_OK && phase_reg == ll1p_pkg::PH_RUN
                    && !(status_reg == ll1p_pkg::ST_TRAIL && !tok_after_run_reg))
                    phase_next = ll1p_pkg::PH_DONE;
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ll1p_pkg::S_CLEAR;
            phase_reg         <= ll1p_pkg::PH_IDLE;
            end_term_reg      <= 4'd15;
            cnt_reg           <= '0;
            clr_reg           <= '0;
            out_valid_reg     <= 1'b0;
            begin_second_reg  <= 1'b0;
            tok_after_run_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            cnt_reg          <= cnt_next;
            begin_second_reg <= accept_in && in_op == ll1p_pkg::OP_BEGIN;
            if (state_reg == ll1p_pkg::S_CLEAR)
                clr_reg <= clr_reg + CA_W'(1);
            if (cfg_we)
                end_term_reg <= cfg_wdata;
            if (accept_in)
                tok_after_run_reg <= in_op == ll1p_pkg::OP_TOKEN
                                     && phase_reg == ll1p_pkg::PH_RUN;
            if (state_reg == ll1p_pkg::S_RESULT)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        k_reg      <= k_next;
        cell_reg   <= cell_next;
        status_reg <= status_next;
        if (accept_in)
        begin
            tok_reg  <= in_tok;
            last_reg <= s_axis_tlast;
        end
    end
endmodule

/* rtl/ll1p_checker.sv */
// Port-level checks for the LL(1) parser, bound to the top level.
`timescale 1ns / 1ps
module ll1p_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);
    a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:3] == 5'd0) else $error("status padding set");
    a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result without processing");
endmodule

bind ll1_table_driven_parser ll1p_checker u_ll1p_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

/* bench/ll1_table_driven_parser_test.sv */
// Self-checking testbench for the LL(1) table-driven parser.
`timescale 1ns / 1ps
module ll1_table_driven_parser_test;
    localparam int NT        = ll1p_pkg::NONTERMINALS_DEF;
    localparam int TM        = ll1p_pkg::TERMINALS_DEF;
    localparam int RHS       = ll1p_pkg::MAX_RHS_DEF;
    localparam int DEPTH     = ll1p_pkg::STACK_DEPTH_DEF;
    localparam int EXP_MAX   = ll1p_pkg::MAX_EXPANSIONS_DEF;
    localparam int N_ITEMS   = 650;
    localparam int MAX_CYC   = 3000000;
    localparam int DRAIN_CYC = 40;
    localparam int NO_CHECK  = -1;
    localparam logic [4:0] TFLAG = 5'h10;

    typedef struct {
        ll1p_pkg::op_t op;
        logic [3:0] row;
        logic [3:0] col;
        logic [2:0] pos;
        logic [3:0] sym;
        logic       isterm;
        logic [3:0] len;
        logic [3:0] tok;
        logic       last;
        int         want;   // typed-in status, or NO_CHECK for the predictor alone
    } parse_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [3:0]  cfg_wdata = 4'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 32'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    ll1_table_driven_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the parser: tables, stack, phase, end-of-input terminal.
    logic [3:0] sh_len [NT*TM];
    logic [4:0] sh_sym [NT*TM*RHS];
    bit         sh_sym_set [NT*TM*RHS];     // slots loaded so far
    logic [4:0] sh_stack [DEPTH];
    int         sh_count;
    ll1p_pkg::phase_t sh_phase;
    logic [3:0] sh_end_term;
    // Scratch stack used for trial walks and for the committed walk alike
    logic [4:0] try_stack [DEPTH];
    int         try_count;

    ll1p_pkg::status_t status_due [$];    // statuses still owed by the block
    parse_item_t directed_rows [$];       // directed stimulus table
    int      items_sent;
    int      mismatches;
    int      cycles;
    bit      no_idle;           // stretch with no idling on the input side

    // Walk one token through the scratch stack, expanding through the table.
    function automatic ll1p_pkg::status_t walk_token(logic [3:0] tok, logic last);
        int         n_exp;
        int         cell_idx;
        int         plen;
        logic [4:0] top;
        logic [4:0] s;
        n_exp = 0;
        while (try_count > 0)
        begin
            try_count--;
            top = try_stack[try_count];
            if (top[4])
            begin
                if (top[3:0] != tok)
                    return ll1p_pkg::ST_MISMATCH;
                if (try_count == 0)
                    return last ? ll1p_pkg::ST_ACCEPT : ll1p_pkg::ST_TRAIL;
                return last ? ll1p_pkg::ST_EOF : ll1p_pkg::ST_OK;
            end
            if (n_exp >= EXP_MAX)
                return ll1p_pkg::ST_LIMIT;
            n_exp++;
            cell_idx = top[3:0] * TM + tok;
            plen = sh_len[cell_idx];
            if (plen == 0)
                return ll1p_pkg::ST_EMPTY;
            // push right to left, epsilon skipped
            for (int k = plen; k > 0; k--)
            begin
                s = sh_sym[cell_idx*RHS + k - 1];
                if (s != TFLAG)
                begin
                    if (try_count >= DEPTH)
                        return ll1p_pkg::ST_OVERFLOW;
                    try_stack[try_count] = s;
                    try_count++;
                end
            end
        end
        return ll1p_pkg::ST_TRAIL;
    endfunction

    function automatic void load_scratch();
        for (int i = 0; i < DEPTH; i++)
            try_stack[i] = sh_stack[i];
        try_count = sh_count;
    endfunction

    // Status the parser owes for one transaction; updates the shadow state.
    function automatic ll1p_pkg::status_t predict_status(parse_item_t it);
        ll1p_pkg::status_t st;
        int      cell_idx;
        st = ll1p_pkg::ST_OK;
        cell_idx = it.row * TM + it.col;
        case (it.op)
            ll1p_pkg::OP_WR_LEN: sh_len[cell_idx] = (it.len > RHS) ? RHS[3:0] : it.len;
            ll1p_pkg::OP_WR_SYM:
            begin
                sh_sym[cell_idx*RHS + it.pos] = {it.isterm, it.sym};
                sh_sym_set[cell_idx*RHS + it.pos] = 1'b1;
            end
            ll1p_pkg::OP_BEGIN:
            begin
                sh_stack[0] = {1'b1, sh_end_term};
                sh_stack[1] = 5'd0;
                sh_count = 2;
                sh_phase = ll1p_pkg::PH_RUN;
            end
            default:
            begin
                if (sh_phase != ll1p_pkg::PH_RUN)
                    st = ll1p_pkg::ST_TRAIL;
                else
                begin
                    load_scratch();
                    st = walk_token(it.tok, it.last);
                    for (int i = 0; i < DEPTH; i++)
                        sh_stack[i] = try_stack[i];
                    sh_count = try_count;
                    if (st != ll1p_pkg::ST_OK)
                        sh_phase = ll1p_pkg::PH_DONE;
                end
            end
        endcase
        return st;
    endfunction

    function automatic parse_item_t mk(ll1p_pkg::op_t op, int row, int col, int pos, int sym,
                                       int isterm, int len, int tok, int last, int want);
        parse_item_t it;
        it.op = op; it.row = 4'(row); it.col = 4'(col); it.pos = 3'(pos); it.sym = 4'(sym);
        it.isterm = 1'(isterm); it.len = 4'(len); it.tok = 4'(tok); it.last = 1'(last);
        it.want = want;
        return it;
    endfunction

    function automatic void add_row(parse_item_t it);
        directed_rows.insert(directed_rows.size(), it);
    endfunction

    // Drive one transaction, wait for acceptance, then record the owed status.
    task automatic send_item(parse_item_t it);
        int      gap;
        ll1p_pkg::status_t st;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, it.tok, it.len, it.isterm, it.sym, it.pos,
                          it.col, it.row, it.op};
        s_axis_tlast  <= it.last;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        st = predict_status(it);
        if (it.want != NO_CHECK && st != ll1p_pkg::status_t'(it.want[2:0]))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row: status %0d typed in, predictor gives %0d",
                         it.want, st);
        end
        status_due.insert(status_due.size(), st);
    endtask

    // A length write first loads any slot inside the length never loaded,
    // so no lookup ever reads an unwritten slot. Fill is nonterminal 0.
    task automatic issue(parse_item_t it);
        int eff;
        int base;
        if (it.op == ll1p_pkg::OP_WR_LEN && it.len != 0)
        begin
            eff  = (it.len > RHS) ? RHS : it.len;
            base = (it.row * TM + it.col) * RHS;
            for (int p = 0; p < eff; p++)
                if (!sh_sym_set[base + p])
                    send_item(mk(ll1p_pkg::OP_WR_SYM, it.row, it.col, p, 0, 0, 0, 0, 0,
                                 ll1p_pkg::ST_OK));
        end
        send_item(it);
    endtask

    // Register writes only with the block idle: nothing owed and a short pause.
    task automatic write_end_term(logic [3:0] v);
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sh_end_term = v;
    endtask

    // Token chosen from the shadow so that the parse keeps going or accepts; random if none does.
    task automatic guided_token(output parse_item_t it);
        int      base;
        ll1p_pkg::status_t st;
        bit      found;
        base  = $urandom_range(0, 15);
        found = 1'b0;
        it = mk(ll1p_pkg::OP_TOKEN, $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 1),
                $urandom_range(0, 15), $urandom_range(0, 15), 0, NO_CHECK);
        for (int k = 0; k < TM && !found; k++)
        begin
            load_scratch();
            st = walk_token(4'((base + k) % TM), 1'b1);
            if (st == ll1p_pkg::ST_ACCEPT && $urandom_range(0, 2) == 0)
            begin
                it.tok = 4'((base + k) % TM); it.last = 1'b1; found = 1'b1;
            end
            else
            begin
                load_scratch();
                st = walk_token(4'((base + k) % TM), 1'b0);
                if (st == ll1p_pkg::ST_OK)
                begin
                    it.tok = 4'((base + k) % TM); found = 1'b1;
                end
            end
        end
        if (!found)
            it.last = 1'($urandom_range(0, 1));
    endtask

    // Random table cell over a small alphabet so parses go deep.
    task automatic random_cell();
        int row;
        int col;
        int len;
        row = $urandom_range(0, 3);
        col = $urandom_range(0, 15);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
        for (int p = 0; p < RHS; p++)
            if ($urandom_range(0, 1) == 1)
                issue(mk(ll1p_pkg::OP_WR_SYM, row, col, p,
                         $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 3),
                         $urandom_range(0, 1), 0, 0, 0, NO_CHECK));
        issue(mk(ll1p_pkg::OP_WR_LEN, row, col, 0, 0, 0, len, 0, 0, NO_CHECK));
    endtask

    task automatic random_noise();
        issue(mk(ll1p_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                 $urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 15),
                 $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 1), NO_CHECK));
    endtask

    // Output side: random stalls per result, compared with the oldest owed status.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        ll1p_pkg::status_t due;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (status_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("status %0d with nothing owed", m_axis_tdata[2:0]);
            end
            else
            begin
                due = status_due.pop_front();
                if (m_axis_tdata[2:0] != due)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("status: expected %0d, got %0d", due, m_axis_tdata[2:0]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYC)
        begin
            $display("ll1_table_driven_parser regression: fail");
            $finish;
        end
    end

    initial
    begin
        parse_item_t it;
        int          phase_no;
        int          n_tok;
        items_sent = 0;
        mismatches = 0;
        cycles     = 0;
        no_idle    = 1'b0;
        for (int i = 0; i < NT*TM; i++)
            sh_len[i] = 4'd0;
        for (int i = 0; i < NT*TM*RHS; i++)
        begin
            sh_sym[i] = 5'd0;
            sh_sym_set[i] = 1'b0;
        end
        for (int i = 0; i < DEPTH; i++)
            sh_stack[i] = 5'd0;
        sh_count    = 0;
        sh_phase    = ll1p_pkg::PH_IDLE;
        sh_end_term = 4'd15;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small grammar N0 -> t1 N1, N1 -> t2 | epsilon on end,
        // plus cells for mismatch, self-loop (expansion limit) and overflow.
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 0, 0, ll1p_pkg::ST_TRAIL)); // no begin
        add_row(mk(ll1p_pkg::OP_WR_SYM, 15, 15, 7, 15, 1, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_WR_SYM, 0, 1, 0, 1, 1, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_WR_SYM, 0, 1, 1, 1, 0, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_WR_LEN, 0, 1, 0, 0, 0, 2, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_WR_SYM, 1, 2, 0, 2, 1, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_WR_LEN, 1, 2, 0, 0, 0, 1, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_WR_SYM, 1, 15, 0, 0, 1, 0, 0, 0, ll1p_pkg::ST_OK)); // epsilon
        add_row(mk(ll1p_pkg::OP_WR_LEN, 1, 15, 0, 0, 0, 1, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_WR_SYM, 0, 4, 0, 5, 1, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_WR_LEN, 0, 4, 0, 0, 0, 1, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_WR_LEN, 0, 6, 0, 0, 0, 1, 0, 0, ll1p_pkg::ST_OK)); // N0 -> N0
        add_row(mk(ll1p_pkg::OP_WR_LEN, 0, 7, 0, 0, 0, 15, 0, 0, ll1p_pkg::ST_OK)); // 8 x N0
        add_row(mk(ll1p_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 1, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 2, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 15, 1, ll1p_pkg::ST_ACCEPT));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 3, 0, ll1p_pkg::ST_TRAIL)); // done
        add_row(mk(ll1p_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 1, 0, NO_CHECK));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 15, 0, ll1p_pkg::ST_TRAIL)); // early
        add_row(mk(ll1p_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 1, 1, ll1p_pkg::ST_EOF)); // left over
        add_row(mk(ll1p_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 3, 0, ll1p_pkg::ST_EMPTY));
        add_row(mk(ll1p_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 4, 0, ll1p_pkg::ST_MISMATCH));
        add_row(mk(ll1p_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 6, 0, ll1p_pkg::ST_LIMIT));
        add_row(mk(ll1p_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, ll1p_pkg::ST_OK));
        add_row(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 7, 0, ll1p_pkg::ST_OVERFLOW));
        foreach (directed_rows[i])
            issue(directed_rows[i]);

        // End terminal at the low extreme: begin, expand, then a last token 0 on an empty cell.
        write_end_term(4'd0);
        issue(mk(ll1p_pkg::OP_WR_LEN, 1, 0, 0, 0, 0, 0, 0, 0, ll1p_pkg::ST_OK));
        issue(mk(ll1p_pkg::OP_BEGIN, 0, 0, 0, 0, 0, 0, 0, 0, ll1p_pkg::ST_OK));
        issue(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 1, 0, ll1p_pkg::ST_OK));
        issue(mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, 0, 1, NO_CHECK));

        // Random phases: a few table cells, then a mostly guided sentence.
        phase_no = 0;
        while (items_sent < N_ITEMS)
        begin
            phase_no++;
            if (phase_no % 8 == 0)
                write_end_term((phase_no % 24 == 0) ? 4'd15 : 4'($urandom_range(0, 15)));
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 4)) random_cell();
            if ($urandom_range(0, 4) == 0)
                random_noise();
            issue(mk(ll1p_pkg::OP_BEGIN, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 1),
                     $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1),
                     NO_CHECK));
            n_tok = 0;
            while (n_tok < 12 && sh_phase == ll1p_pkg::PH_RUN)
            begin
                if ($urandom_range(0, 9) < 8)
                    guided_token(it);
                else
                    it = mk(ll1p_pkg::OP_TOKEN, 0, 0, 0, 0, 0, 0, $urandom_range(0, 15),
                            $urandom_range(0, 1), NO_CHECK);
                issue(it);
                n_tok++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0)
            $display("ll1_table_driven_parser regression: pass");
        else
            $display("ll1_table_driven_parser regression: fail");
        $finish;
    end
endmodule

/* files.f */
rtl/ll1p_pkg.sv
rtl/ll1p_table.sv
rtl/ll1p_stack.sv
rtl/ll1_table_driven_parser.sv
rtl/ll1p_checker.sv
bench/ll1_table_driven_parser_test.sv
